@@ src/qts_pkg.sv @@
// ---------------------------------------------------------------------------
// qts_pkg: shared types and constants for the quoted token splitter
// Result kinds, one-hot scan modes, byte constants and the decode record.
// ---------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

	// Number of results one input byte can release
	localparam int MAX_RESULTS = 4;

	// Byte constants
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_NONE      = 8'h00;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_LINE_END  = 2'd2
	} kind_t;

	// Scan modes, one-hot
	typedef enum logic [5:0] {
		MODE_BETWEEN = 6'b000001,
		MODE_BARE    = 6'b000010,
		MODE_QUOTED  = 6'b000100,
		MODE_ESCAPE  = 6'b001000,
		MODE_SLASH   = 6'b010000,
		MODE_COMMENT = 6'b100000
	} mode_t;

	// Decoded results of one byte plus the follow-on mode
	typedef struct packed {
		logic [2:0]            count;
		kind_t [3:0]           kinds;
		logic [3:0][7:0]       chars;
		mode_t                 next_mode;
	} dec_t;

endpackage

`default_nettype wire

@@ src/qts_decode.sv @@
// ---------------------------------------------------------------------------
// qts_decode: byte classifier and result builder
// Maps the current scan mode and one byte to up to four results and the
// next scan mode, in one pass of combinational logic.
// ---------------------------------------------------------------------------
`default_nettype none

module qts_decode (
	input  wire qts_pkg::mode_t mode,
	input  wire logic [7:0]     char_in,
	input  wire logic           line_end,
	output qts_pkg::dec_t       dec
);

	// Append one result to the record
	function automatic qts_pkg::dec_t push(qts_pkg::dec_t d, qts_pkg::kind_t k,
		logic [7:0] ch);
		d.kinds[d.count[1:0]] = k;
		d.chars[d.count[1:0]] = ch;
		d.count = d.count + 3'd1;
		return d;
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == qts_pkg::CH_SPACE) || (c == qts_pkg::CH_TAB);
	endfunction

	// Handle one byte inside or at the start of a bare token
	function automatic qts_pkg::dec_t bare_byte(qts_pkg::dec_t d, logic [7:0] c);
		if (is_blank(c)) begin
			d = push(d, qts_pkg::KIND_TOKEN_END, qts_pkg::CH_NONE);
			d.next_mode = qts_pkg::MODE_BETWEEN;
		end else begin
			d = push(d, qts_pkg::KIND_DATA, c);
			d.next_mode = qts_pkg::MODE_BARE;
		end
		return d;
	endfunction

	always_comb begin
		qts_pkg::dec_t d;
		d.count     = 3'd0;
		d.kinds     = {qts_pkg::MAX_RESULTS{qts_pkg::KIND_DATA}};
		d.chars     = '0;
		d.next_mode = mode;

		// Step the scan mode on this byte
		unique case (mode)
			qts_pkg::MODE_BARE: begin
				d = bare_byte(d, char_in);
			end
			qts_pkg::MODE_QUOTED: begin
				if (char_in == qts_pkg::CH_QUOTE) begin
					d = push(d, qts_pkg::KIND_TOKEN_END, qts_pkg::CH_NONE);
					d.next_mode = qts_pkg::MODE_BETWEEN;
				end else if (char_in == qts_pkg::CH_BACKSLASH) begin
					if (line_end) begin
						d = push(d, qts_pkg::KIND_DATA, char_in);
					end else begin
						d.next_mode = qts_pkg::MODE_ESCAPE;
					end
				end else begin
					d = push(d, qts_pkg::KIND_DATA, char_in);
				end
			end
			qts_pkg::MODE_ESCAPE: begin
				if (char_in == qts_pkg::CH_N) begin
					d = push(d, qts_pkg::KIND_DATA, qts_pkg::CH_NEWLINE);
				end else if (char_in == qts_pkg::CH_T) begin
					d = push(d, qts_pkg::KIND_DATA, qts_pkg::CH_TAB);
				end else begin
					d = push(d, qts_pkg::KIND_DATA, char_in);
				end
				d.next_mode = qts_pkg::MODE_QUOTED;
			end
			qts_pkg::MODE_SLASH: begin
				if (char_in == qts_pkg::CH_SLASH) begin
					d.next_mode = qts_pkg::MODE_COMMENT;
				end else begin
					// release the held slash, then treat the byte as bare
					d = push(d, qts_pkg::KIND_DATA, qts_pkg::CH_SLASH);
					d = bare_byte(d, char_in);
				end
			end
			qts_pkg::MODE_COMMENT: begin
				d.next_mode = qts_pkg::MODE_COMMENT;
			end
			default: begin
				// between tokens, and any stray code
				if (is_blank(char_in)) begin
					d.next_mode = qts_pkg::MODE_BETWEEN;
				end else if (char_in == qts_pkg::CH_QUOTE) begin
					d.next_mode = qts_pkg::MODE_QUOTED;
				end else if ((char_in == qts_pkg::CH_SLASH) && !line_end) begin
					d.next_mode = qts_pkg::MODE_SLASH;
				end else begin
					d = push(d, qts_pkg::KIND_DATA, char_in);
					d.next_mode = qts_pkg::MODE_BARE;
				end
			end
		endcase

		// Close any open token and the line on its last byte
		if (line_end) begin
			if ((d.next_mode == qts_pkg::MODE_BARE) ||
				(d.next_mode == qts_pkg::MODE_QUOTED) ||
				(d.next_mode == qts_pkg::MODE_ESCAPE)) begin
				d = push(d, qts_pkg::KIND_TOKEN_END, qts_pkg::CH_NONE);
			end
			d = push(d, qts_pkg::KIND_LINE_END, qts_pkg::CH_NONE);
			d.next_mode = qts_pkg::MODE_BETWEEN;
		end

		dec = d;
	end

endmodule

`default_nettype wire

@@ src/qts_result_buf.sv @@
// ---------------------------------------------------------------------------
// qts_result_buf: result register and serializer
// Holds one byte's results, handing out one per cycle while out_ready is high
// and marking the final one. Takes a new set in the cycle the old one drains.
// ---------------------------------------------------------------------------
`default_nettype none

module qts_result_buf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire qts_pkg::dec_t  dec,
	output logic                free,
	output logic                out_valid,
	input  wire logic           out_ready,
	output qts_pkg::kind_t      kind,
	output logic [7:0]          out_char,
	output logic                last
);

	logic [2:0]           count_q;
	logic [1:0]           rd_q;
	qts_pkg::kind_t [3:0] kinds_q;
	logic [3:0][7:0]      chars_q;
	logic                 pop;
	logic                 final_one;

	// Present the entry at the read pointer
	assign out_valid = (count_q != 3'd0);
	assign final_one = ({1'b0, rd_q} == (count_q - 3'd1));
	assign last      = final_one;
	assign kind      = kinds_q[rd_q];
	assign out_char  = chars_q[rd_q];

	// Free once empty or when the final result leaves this cycle
	assign pop  = out_valid && out_ready;
	assign free = !out_valid || (pop && final_one);

	// Advance the read pointer, drop the set when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
			rd_q    <= 2'd0;
		end else if (load) begin
			count_q <= dec.count;
			rd_q    <= 2'd0;
		end else if (pop) begin
			if (final_one) begin
				count_q <= 3'd0;
				rd_q    <= 2'd0;
			end else begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	// Capture result payload
	always_ff @(posedge clk) begin
		if (load) begin
			kinds_q <= dec.kinds;
			chars_q <= dec.chars;
		end
	end

endmodule

`default_nettype wire

@@ src/quoted_token_splitter_top.sv @@
// A byte is held in the input register and decoded from there; its results are
// offered once they are loaded into the result buffer.
// Throughput: one byte per cycle while bytes release at most one result and the
// receiver is ready; otherwise the input stalls while the result buffer drains.
// Reset: clears the input stage, empties the result buffer and returns the
// scanner to between tokens.
// ---------------------------------------------------------------------------
// quoted_token_splitter_top: line tokenizer with quoting and escapes
// Input register, one-pass decode with the scan mode register, and a
// serializing result buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module quoted_token_splitter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_in,
	input  wire logic        line_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       out_char,
	output logic             last
);

	logic           valid_s1;
	logic [7:0]     char_s1;
	logic           line_end_s1;
	qts_pkg::mode_t mode_q;
	qts_pkg::dec_t  dec;
	qts_pkg::kind_t kind_int;
	logic           buf_free;
	logic           move;

	// Move the staged byte into the result buffer when it has room
	assign move     = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || move;

	// Hold the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1     <= char_in;
			line_end_s1 <= line_end;
		end
	end

	// Advance the scan mode as each byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= qts_pkg::MODE_BETWEEN;
		end else if (move) begin
			mode_q <= dec.next_mode;
		end
	end

	qts_decode u_decode (
		.mode     (mode_q),
		.char_in  (char_s1),
		.line_end (line_end_s1),
		.dec      (dec)
	);

	qts_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (move),
		.dec       (dec),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind_int),
		.out_char  (out_char),
		.last      (last)
	);

	assign kind = kind_int;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb: self-checking bench for the quoted token splitter
// Feeds text lines one byte per request and predicts the emitted token bytes,
// token ends and line ends. Each result is checked in order against that
// prediction. The run covers directed special cases and random lines under
// varying sender and receiver idling, plus one long output stall.
// ---------------------------------------------------------------------------
module tb;

	localparam int QUIET_LIMIT = 1000;
	localparam int STALL_CYCLES = 150;
	localparam int EXP_DEPTH = 1024;

	typedef struct {
		qts_pkg::kind_t kind;
		logic [7:0]     ch;
		logic           last;
	} piece_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_in;
	logic       line_end;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] out_kind;
	logic [7:0] out_ch;
	logic       out_last;

	// Expected results in a ring, written at wr_idx and checked at rd_idx
	piece_t         exp_mem[EXP_DEPTH];
	int             wr_idx;
	int             rd_idx;
	int             step_count;
	qts_pkg::mode_t scan_state;

	int errors;
	int in_idle_pct;
	int out_idle_pct;
	int hold_left;
	int quiet;

	quoted_token_splitter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_in   (char_in),
		.line_end  (line_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (out_kind),
		.out_char  (out_ch),
		.last      (out_last)
	);

	always #6 clk = ~clk;

	// Token splitting predictor
	function automatic void emit_piece(qts_pkg::kind_t k, logic [7:0] c);
		piece_t p;
		p.kind = k;
		p.ch = c;
		p.last = 1'b0;
		exp_mem[wr_idx % EXP_DEPTH] = p;
		wr_idx++;
		step_count++;
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == qts_pkg::CH_SPACE) || (c == qts_pkg::CH_TAB);
	endfunction

	// Continue or start a bare token with this byte
	function automatic void bare_byte(logic [7:0] c);
		if (is_blank(c)) begin
			emit_piece(qts_pkg::KIND_TOKEN_END, qts_pkg::CH_NONE);
			scan_state = qts_pkg::MODE_BETWEEN;
		end else begin
			emit_piece(qts_pkg::KIND_DATA, c);
			scan_state = qts_pkg::MODE_BARE;
		end
	endfunction

	function automatic void split_byte(logic [7:0] c, logic e);
		step_count = 0;
		case (scan_state)
			qts_pkg::MODE_BARE: bare_byte(c);
			qts_pkg::MODE_QUOTED: begin
				if (c == qts_pkg::CH_QUOTE) begin
					emit_piece(qts_pkg::KIND_TOKEN_END, qts_pkg::CH_NONE);
					scan_state = qts_pkg::MODE_BETWEEN;
				end else if (c == qts_pkg::CH_BACKSLASH) begin
					// a backslash on the last byte stays literal
					if (e)
						emit_piece(qts_pkg::KIND_DATA, c);
					else
						scan_state = qts_pkg::MODE_ESCAPE;
				end else begin
					emit_piece(qts_pkg::KIND_DATA, c);
				end
			end
			qts_pkg::MODE_ESCAPE: begin
				if (c == qts_pkg::CH_N)
					emit_piece(qts_pkg::KIND_DATA, qts_pkg::CH_NEWLINE);
				else if (c == qts_pkg::CH_T)
					emit_piece(qts_pkg::KIND_DATA, qts_pkg::CH_TAB);
				else
					emit_piece(qts_pkg::KIND_DATA, c);
				scan_state = qts_pkg::MODE_QUOTED;
			end
			qts_pkg::MODE_SLASH: begin
				if (c == qts_pkg::CH_SLASH) begin
					scan_state = qts_pkg::MODE_COMMENT;
				end else begin
					// release the held slash, then treat the byte as bare
					emit_piece(qts_pkg::KIND_DATA, qts_pkg::CH_SLASH);
					bare_byte(c);
				end
			end
			qts_pkg::MODE_COMMENT: ;
			default: begin
				if (is_blank(c)) begin
					scan_state = qts_pkg::MODE_BETWEEN;
				end else if (c == qts_pkg::CH_QUOTE) begin
					scan_state = qts_pkg::MODE_QUOTED;
				end else if (c == qts_pkg::CH_SLASH && !e) begin
					scan_state = qts_pkg::MODE_SLASH;
				end else begin
					emit_piece(qts_pkg::KIND_DATA, c);
					scan_state = qts_pkg::MODE_BARE;
				end
			end
		endcase

		// Close any open token and the line
		if (e) begin
			if ((scan_state == qts_pkg::MODE_BARE) ||
				(scan_state == qts_pkg::MODE_QUOTED) ||
				(scan_state == qts_pkg::MODE_ESCAPE))
				emit_piece(qts_pkg::KIND_TOKEN_END, qts_pkg::CH_NONE);
			emit_piece(qts_pkg::KIND_LINE_END, qts_pkg::CH_NONE);
			scan_state = qts_pkg::MODE_BETWEEN;
		end

		// Mark the final result of this byte
		if (step_count > 0)
			exp_mem[(wr_idx - 1) % EXP_DEPTH].last = 1'b1;
	endfunction

	// Send one byte request, with a random gap before it
	task automatic send_byte(input logic [7:0] c, input logic e);
		int gap;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			char_in <= 8'($urandom_range(255));
			line_end <= 1'($urandom_range(1));
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		line_end <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		split_byte(c, e);
	endtask

	// Drop the request and wait until every expected result has arrived
	task automatic drain();
		in_valid <= 1'b0;
		while (rd_idx != wr_idx)
			@(posedge clk);
	endtask

	// Weighted byte choice so that quotes, escapes and slashes show up often
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 8'h61 + 8'($urandom_range(25)); // lower-case letter
		else if (r < 35)
			return qts_pkg::CH_SPACE;
		else if (r < 40)
			return qts_pkg::CH_TAB;
		else if (r < 50)
			return qts_pkg::CH_QUOTE;
		else if (r < 58)
			return qts_pkg::CH_BACKSLASH;
		else if (r < 66)
			return qts_pkg::CH_SLASH;
		else if (r < 70)
			return qts_pkg::CH_N;
		else if (r < 74)
			return qts_pkg::CH_T;
		return 8'($urandom_range(255));
	endfunction

	task automatic test_special_cases();
		// Byte extremes as a bare token
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		// Escapes, escaped quote, tab separator, empty quoted, slash on last byte
		send_byte(qts_pkg::CH_QUOTE, 1'b0);
		send_byte(qts_pkg::CH_BACKSLASH, 1'b0);
		send_byte(qts_pkg::CH_N, 1'b0);
		send_byte(qts_pkg::CH_BACKSLASH, 1'b0);
		send_byte(qts_pkg::CH_T, 1'b0);
		send_byte(qts_pkg::CH_BACKSLASH, 1'b0);
		send_byte(qts_pkg::CH_QUOTE, 1'b0);
		send_byte(qts_pkg::CH_QUOTE, 1'b0);
		send_byte(qts_pkg::CH_TAB, 1'b0);
		send_byte(qts_pkg::CH_QUOTE, 1'b0);
		send_byte(qts_pkg::CH_QUOTE, 1'b0);
		send_byte(qts_pkg::CH_SLASH, 1'b1);
		// Held slash released, then a comment that still ends the line
		send_byte(qts_pkg::CH_SLASH, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte(qts_pkg::CH_SPACE, 1'b0);
		send_byte(qts_pkg::CH_SLASH, 1'b0);
		send_byte(qts_pkg::CH_SLASH, 1'b0);
		send_byte(8'h7A, 1'b0);
		send_byte(qts_pkg::CH_BACKSLASH, 1'b1);
		// Unclosed quote with a backslash on the last byte
		send_byte(qts_pkg::CH_QUOTE, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(qts_pkg::CH_BACKSLASH, 1'b1);
	endtask

	task automatic test_random_lines(input int n_bytes);
		int sent;
		int len;
		sent = 0;
		while (sent < n_bytes) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 12);
			if (sent + len > n_bytes)
				len = n_bytes - sent;
			for (int i = 0; i < len; i++) begin
				// mostly whole lines; now and then an early line end
				send_byte(pick_char(), (i == len - 1) || ($urandom_range(19) == 0));
				sent++;
			end
		end
	endtask

	// Hold the receiver off while bytes keep coming, so the input stalls
	task automatic test_output_stall();
		hold_left <= STALL_CYCLES;
		for (int i = 0; i < 20; i++)
			send_byte(pick_char(), i == 19);
	endtask

	// Receiver: check each result and pick the next ready
	always @(posedge clk) begin
		piece_t exp;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (rd_idx == wr_idx) begin
					errors++;
					$display("%0t: unexpected result kind=%0d char=%02h last=%0b",
						$time, out_kind, out_ch, out_last);
				end else begin
					exp = exp_mem[rd_idx % EXP_DEPTH];
					rd_idx++;
					if (out_kind !== exp.kind) begin
						errors++;
						$display("%0t: kind expected %0d got %0d", $time, exp.kind, out_kind);
					end
					if (out_ch !== exp.ch) begin
						errors++;
						$display("%0t: out_char expected %02h got %02h", $time, exp.ch, out_ch);
					end
					if (out_last !== exp.last) begin
						errors++;
						$display("%0t: last expected %0b got %0b", $time, exp.last, out_last);
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
		end
	end

	// Count down the receiver hold-off
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_in = 8'h00;
		line_end = 1'b0;
		out_ready = 1'b0;
		errors = 0;
		hold_left = 0;
		quiet = 0;
		wr_idx = 0;
		rd_idx = 0;
		step_count = 0;
		in_idle_pct = 16;
		out_idle_pct = 64;
		scan_state = qts_pkg::MODE_BETWEEN;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_random_lines(35);
		drain();

		in_idle_pct = 64;
		out_idle_pct = 16;
		test_random_lines(35);
		drain();

		in_idle_pct = 0;
		out_idle_pct = 0;
		test_output_stall();
		test_random_lines(16);
		drain();

		// Let any stray result show up
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ quoted_token_splitter_top.f @@
src/qts_pkg.sv
src/qts_decode.sv
src/qts_result_buf.sv
src/quoted_token_splitter_top.sv
tb/tb.sv
